// ===== design/svrt_pkg.sv =====
// Shared types and width helpers for the spatial vector rigid transform.
// No dependencies; imported by every module of the block.
package svrt_pkg;

  // Item kind carried in tuser; the remaining code means "no operation"
  typedef enum logic [1:0] {
    OP_POINT  = 2'd0,
    OP_MOTION = 2'd1,
    OP_FORCE  = 2'd2
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ROT0  = 2'd0,
    REG_ROT1  = 2'd1,
    REG_ROT2  = 2'd2,
    REG_TRANS = 2'd3
  } reg_idx_e;

  // Width of a rounded rotation row sum, never below data width plus one
  function automatic int rot_sum_w(int dw, int rfb);
    int w;
    w = 2 * dw + 2 - rfb;
    return (w > dw + 1) ? w : dw + 1;
  endfunction

  // Width of a rounded cross product term, never below data width plus one
  function automatic int cross_w(int dw, int vfb);
    int w;
    w = 2 * dw + 1 - vfb;
    return (w > dw + 1) ? w : dw + 1;
  endfunction

endpackage

// ===== design/spatial_vector_rigid_transform.sv =====
// Top level of the spatial vector rigid transform: configuration registers,
// input stage, three row lanes, merging stage and output register.
// Depends on svrt_pkg, svrt_lane and svrt_merge.
//
// Usage:
//   Input items arrive on the s_ channel: s_tuser holds the operation
//   (point, motion vector or force vector), s_tdata holds v0..v5.
//   Results leave on the m_ channel: m_tdata holds r0..r5, m_tuser holds
//   the saturation flag. One result item leaves for every input item.
//   The rotation rows and the translation sit in four 48-bit registers on
//   the APB-style port at byte addresses 0, 8, 16 and 24; write them only
//   while no item is in flight.
// Pipeline and throughput:
//   Five register stages (input, products, row sums, cross products,
//   output). One item per cycle is taken while the output is not stalled;
//   three lanes, one per rotation row, each with six multipliers, plus six
//   cross product multipliers set that rate.
// Reset:
//   rst empties the pipeline and loads the identity rotation and a zero
//   translation.
// Stall:
//   While m_tvalid is high and m_tready low, every stage holds and s_tready
//   drops; nothing is lost or repeated.
module spatial_vector_rigid_transform
  import svrt_pkg::*;
#(
  parameter int ROT_FRAC_BITS = 14,
  parameter int VEC_FRAC_BITS = 8,
  parameter int DATA_WIDTH    = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input item channel
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // v0..v5 from bit 0 up, DATA_WIDTH bits each, zero fill to whole bytes
  input  logic [((6 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  // operation
  input  logic [1:0]                             s_tuser,
  // result item channel
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // r0..r5 from bit 0 up, DATA_WIDTH bits each, zero fill to whole bytes
  output logic [((6 * DATA_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
  // saturated
  output logic [0:0]                             m_tuser,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [4:0]                             paddr,
  input  logic [63:0]                            pwdata,
  output logic [63:0]                            prdata,
  output logic                                   pready
);

  localparam int DW      = DATA_WIDTH;
  localparam int TDATA_W = ((6 * DW + 7) / 8) * 8;
  localparam int EXT_W   = 3 * DW;
  // keep register bits that an entry can reach, at least the 48 written
  localparam int REG_W   = (EXT_W > 48) ? ((EXT_W > 64) ? 64 : EXT_W) : 48;
  localparam int TW      = rot_sum_w(DW, ROT_FRAC_BITS);

  localparam logic [63:0] ONE = 64'd1;
  localparam logic [REG_W-1:0] ROW0_RST = REG_W'(ONE << ROT_FRAC_BITS);
  localparam logic [REG_W-1:0] ROW1_RST = REG_W'(ONE << (DW + ROT_FRAC_BITS));
  localparam logic [REG_W-1:0] ROW2_RST = REG_W'(ONE << (2 * DW + ROT_FRAC_BITS));

  logic [REG_W-1:0] rot_row [3];
  logic [REG_W-1:0] trans;

  logic [EXT_W-1:0]     row_ext [3];
  logic [EXT_W-1:0]     trans_ext;
  logic signed [DW-1:0] rot_e [3][3];
  logic signed [DW-1:0] p_e [3];

  logic                 adv;
  logic                 vld1, vld2, vld3, vld4;
  logic [1:0]           op1, op2, op3;
  logic signed [DW-1:0] x_in [6];
  logic signed [DW-1:0] a_next [3];
  logic signed [DW-1:0] b_next [3];
  logic signed [DW-1:0] a1 [3];
  logic signed [DW-1:0] b1 [3];

  logic signed [DW-1:0] ta_sat [3];
  logic [2:0]           ta_ovf;
  logic signed [TW-1:0] tb [3];

  logic signed [DW-1:0] r_m [6];
  logic                 sat_m;
  logic [TDATA_W-1:0]   pack;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row[0] <= ROW0_RST;
      rot_row[1] <= ROW1_RST;
      rot_row[2] <= ROW2_RST;
      trans      <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_e'(paddr[4:3]))
        REG_ROT0:  rot_row[0] <= REG_W'(pwdata[47:0]);
        REG_ROT1:  rot_row[1] <= REG_W'(pwdata[47:0]);
        REG_ROT2:  rot_row[2] <= REG_W'(pwdata[47:0]);
        REG_TRANS: trans      <= REG_W'(pwdata[47:0]);
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[4:3]))
      REG_ROT0:  prdata = 64'(rot_row[0]);
      REG_ROT1:  prdata = 64'(rot_row[1]);
      REG_ROT2:  prdata = 64'(rot_row[2]);
      REG_TRANS: prdata = 64'(trans);
    endcase
  end

  // Unpack entries; register bits past the stored width read as zero
  always_comb begin
    trans_ext = EXT_W'(trans);
    for (int i = 0; i < 3; i++) begin
      row_ext[i] = EXT_W'(rot_row[i]);
      p_e[i]     = trans_ext[i * DW +: DW];
      for (int j = 0; j < 3; j++) begin
        rot_e[i][j] = row_ext[i][j * DW +: DW];
      end
    end
  end

  // ---------------------------------------------------------- flow control
  // Every stage advances together unless a finished result is held
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1     <= 1'b0;
      vld2     <= 1'b0;
      vld3     <= 1'b0;
      vld4     <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vld1     <= s_tvalid;
      vld2     <= vld1;
      vld3     <= vld2;
      vld4     <= vld3;
      m_tvalid <= vld4;
    end
  end

  // ----------------------------------------------------------- input stage
  // Route the block that is rotated alone to a, the block that also takes
  // the cross product (or translation, for a point) to b.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      x_in[k] = s_tdata[k * DW +: DW];
    end
    for (int i = 0; i < 3; i++) begin
      a_next[i] = '0;
      b_next[i] = '0;
    end
    case (s_tuser)
      OP_POINT: begin
        for (int i = 0; i < 3; i++) b_next[i] = x_in[i];
      end
      OP_MOTION: begin
        for (int i = 0; i < 3; i++) begin
          a_next[i] = x_in[i + 3];
          b_next[i] = x_in[i];
        end
      end
      OP_FORCE: begin
        for (int i = 0; i < 3; i++) begin
          a_next[i] = x_in[i];
          b_next[i] = x_in[i + 3];
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) b_next[i] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1 <= s_tuser;
      a1  <= a_next;
      b1  <= b_next;
      op2 <= op1;
      op3 <= op2;
    end
  end

  // ------------------------------------------------------------ row lanes
  for (genvar i = 0; i < 3; i++) begin : g_lane
    svrt_lane #(
      .DATA_WIDTH    (DATA_WIDTH),
      .ROT_FRAC_BITS (ROT_FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (adv),
      .row    (rot_e[i]),
      .a      (a1),
      .b      (b1),
      .ta_sat (ta_sat[i]),
      .ta_ovf (ta_ovf[i]),
      .tb     (tb[i])
    );
  end

  // --------------------------------------------------------- merging stage
  svrt_merge #(
    .DATA_WIDTH    (DATA_WIDTH),
    .ROT_FRAC_BITS (ROT_FRAC_BITS),
    .VEC_FRAC_BITS (VEC_FRAC_BITS)
  ) u_merge (
    .clk    (clk),
    .en     (adv),
    .op     (op3),
    .ta_sat (ta_sat),
    .ta_ovf (ta_ovf),
    .tb     (tb),
    .p      (p_e),
    .r      (r_m),
    .sat    (sat_m)
  );

  // --------------------------------------------------------- output stage
  always_comb begin
    pack = '0;
    for (int k = 0; k < 6; k++) begin
      pack[k * DW +: DW] = r_m[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= pack;
      m_tuser <= sat_m;
    end
  end

endmodule

// ===== design/svrt_lane.sv =====
// One rotation row lane: multiplies a row of R with two 3-vectors, rounds the
// row sums and saturates the first one. Depends on svrt_pkg.
module svrt_lane
  import svrt_pkg::*;
#(
  parameter int DATA_WIDTH    = 16,
  parameter int ROT_FRAC_BITS = 14
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [DATA_WIDTH-1:0] row [3],
  input  logic signed [DATA_WIDTH-1:0] a [3],
  input  logic signed [DATA_WIDTH-1:0] b [3],
  output logic signed [DATA_WIDTH-1:0] ta_sat,
  output logic                         ta_ovf,
  output logic signed [rot_sum_w(DATA_WIDTH, ROT_FRAC_BITS)-1:0] tb
);

  localparam int DW    = DATA_WIDTH;
  localparam int PW    = 2 * DW;
  localparam int SW    = 2 * DW + 2;
  localparam int TW    = rot_sum_w(DW, ROT_FRAC_BITS);
  localparam int RBIAS = (1 << ROT_FRAC_BITS) >> 1;

  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW - 1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW - 1){1'b0}}};

  logic signed [PW-1:0] pa [3];
  logic signed [PW-1:0] pb [3];
  logic signed [SW-1:0] sum_a, sum_b, sh_a, sh_b;
  logic signed [TW-1:0] ta_full, tb_next;
  logic                 ovf_next;
  logic signed [DW-1:0] sat_next;

  // Product stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pa[j] <= row[j] * a[j];
        pb[j] <= row[j] * b[j];
      end
    end
  end

  // Exact row sum, round half up, then saturate the first result
  always_comb begin
    sum_a    = SW'(pa[0]) + SW'(pa[1]) + SW'(pa[2]) + SW'(RBIAS);
    sum_b    = SW'(pb[0]) + SW'(pb[1]) + SW'(pb[2]) + SW'(RBIAS);
    sh_a     = sum_a >>> ROT_FRAC_BITS;
    sh_b     = sum_b >>> ROT_FRAC_BITS;
    ta_full  = sh_a[TW-1:0];
    tb_next  = sh_b[TW-1:0];
    ovf_next = !((&ta_full[TW-1:DW-1]) || !(|ta_full[TW-1:DW-1]));
    if (ovf_next) begin
      sat_next = ta_full[TW-1] ? MINV : MAXV;
    end else begin
      sat_next = ta_full[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ta_sat <= sat_next;
      ta_ovf <= ovf_next;
      tb     <= tb_next;
    end
  end

endmodule

// ===== design/svrt_merge.sv =====
// Merging stage: cross product of the translation with the saturated first
// block across all lanes, final add, saturation and output placement.
// Depends on svrt_pkg.
module svrt_merge
  import svrt_pkg::*;
#(
  parameter int DATA_WIDTH    = 16,
  parameter int ROT_FRAC_BITS = 14,
  parameter int VEC_FRAC_BITS = 8
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [1:0]                   op,
  input  logic signed [DATA_WIDTH-1:0] ta_sat [3],
  input  logic [2:0]                   ta_ovf,
  input  logic signed [rot_sum_w(DATA_WIDTH, ROT_FRAC_BITS)-1:0] tb [3],
  input  logic signed [DATA_WIDTH-1:0] p [3],
  output logic signed [DATA_WIDTH-1:0] r [6],
  output logic                         sat
);

  localparam int DW    = DATA_WIDTH;
  localparam int PW    = 2 * DW;
  localparam int XW    = 2 * DW + 1;
  localparam int TW    = rot_sum_w(DW, ROT_FRAC_BITS);
  localparam int CW    = cross_w(DW, VEC_FRAC_BITS);
  localparam int FW    = ((TW > CW) ? TW : CW) + 1;
  localparam int VBIAS = (1 << VEC_FRAC_BITS) >> 1;

  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW - 1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW - 1){1'b0}}};

  logic [1:0]           op_q;
  logic signed [DW-1:0] ta_q [3];
  logic [2:0]           ovf_q;
  logic signed [TW-1:0] tb_q [3];
  logic signed [PW-1:0] pr1 [3];
  logic signed [PW-1:0] pr2 [3];

  logic signed [XW-1:0] diff [3];
  logic signed [XW-1:0] csh [3];
  logic signed [CW-1:0] addend [3];
  logic signed [FW-1:0] sum [3];
  logic signed [DW-1:0] s [3];
  logic [2:0]           s_ovf;

  // Cross product partial products: p x ta
  always_ff @(posedge clk) begin
    if (en) begin
      op_q   <= op;
      ta_q   <= ta_sat;
      ovf_q  <= ta_ovf;
      tb_q   <= tb;
      pr1[0] <= p[1] * ta_sat[2];
      pr2[0] <= p[2] * ta_sat[1];
      pr1[1] <= p[2] * ta_sat[0];
      pr2[1] <= p[0] * ta_sat[2];
      pr1[2] <= p[0] * ta_sat[1];
      pr2[2] <= p[1] * ta_sat[0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = XW'(pr1[i]) - XW'(pr2[i]) + XW'(VBIAS);
      csh[i]  = diff[i] >>> VEC_FRAC_BITS;
      // a point adds the translation itself instead of a cross product
      if (op_q == OP_POINT) begin
        addend[i] = CW'(p[i]);
      end else begin
        addend[i] = csh[i][CW-1:0];
      end
      sum[i]   = FW'(tb_q[i]) + FW'(addend[i]);
      s_ovf[i] = !((&sum[i][FW-1:DW-1]) || !(|sum[i][FW-1:DW-1]));
      if (s_ovf[i]) begin
        s[i] = sum[i][FW-1] ? MINV : MAXV;
      end else begin
        s[i] = sum[i][DW-1:0];
      end
    end

    for (int k = 0; k < 6; k++) begin
      r[k] = '0;
    end
    sat = 1'b0;
    case (op_q)
      OP_POINT: begin
        for (int i = 0; i < 3; i++) r[i] = s[i];
        sat = |s_ovf;
      end
      OP_MOTION: begin
        for (int i = 0; i < 3; i++) begin
          r[i]     = s[i];
          r[i + 3] = ta_q[i];
        end
        sat = (|s_ovf) || (|ovf_q);
      end
      OP_FORCE: begin
        for (int i = 0; i < 3; i++) begin
          r[i]     = ta_q[i];
          r[i + 3] = s[i];
        end
        sat = (|s_ovf) || (|ovf_q);
      end
      default: begin
        sat = 1'b0;
      end
    endcase
  end

endmodule

// ===== bench/spatial_vector_rigid_transform_tb.sv =====
// Self-checking bench for spatial_vector_rigid_transform: streams points, motion
// and force vectors under several rigid frames and checks every result item.
// Depends on svrt_pkg and the block's top level; nothing else.
`timescale 1ns / 100ps

module spatial_vector_rigid_transform_tb;
  import svrt_pkg::*;

  localparam int ROT_FB = 14;
  localparam int VEC_FB = 8;
  localparam int DW     = 16;

  // code left over in the two-bit operation field: yields an all-zero result
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic        drain;  // hold this item back until every result is in
    logic [1:0]  op;
    logic [95:0] data;
  } vec_item_t;

  typedef struct packed {
    logic [95:0] r;
    logic        sat;
  } vec_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // v0..v5 from bit 0 up, 16 bits each
  logic [95:0] s_tdata = '0;
  // operation
  logic [1:0]  s_tuser = OP_POINT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // r0..r5 from bit 0 up, 16 bits each
  logic [95:0] m_tdata;
  // saturated
  logic [0:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  spatial_vector_rigid_transform #(
    .ROT_FRAC_BITS(ROT_FB),
    .VEC_FRAC_BITS(VEC_FB),
    .DATA_WIDTH   (DW)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the frame registers, indexed by register code
  logic [47:0] frame_reg [4];

  vec_item_t   pending_items[$];
  vec_result_t expected_results[$];
  int          fail_count = 0;
  bit          calm_phase = 1'b0;  // no idling on either side while set

  int          send_gap;
  int          recv_stall;
  vec_item_t   next_item;
  vec_result_t want;
  bit          bad;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Report the first ten failures in full, count the rest
  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  // Gap length: drawn from three ranges, the shortest most often and the longest rarely
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: rigid frame applied to one item, exact integer arithmetic
  // ---------------------------------------------------------------------------
  function automatic longint rot_at(int i, int j);
    return longint'($signed(frame_reg[i][16*j +: 16]));
  endfunction

  // One rotation row times a vector, rounded half up to the vector format
  function automatic longint row_dot(int i, longint a, longint b, longint c);
    return (rot_at(i, 0) * a + rot_at(i, 1) * b + rot_at(i, 2) * c +
            (longint'(1) << (ROT_FB - 1))) >>> ROT_FB;
  endfunction

  // Clip to the signed 16-bit range, raising the flag when clipping
  function automatic longint clip16(longint v, inout bit flag);
    if (v > 32767) begin
      flag = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      flag = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  function automatic vec_result_t transform_item(logic [1:0] op, logic [95:0] vin);
    longint      x[6];
    longint      res[6];
    longint      p[3];
    longint      c[3];
    longint      half;
    bit          flag;
    int          first;
    int          second;
    vec_result_t o;
    flag = 1'b0;
    half = longint'(1) << (VEC_FB - 1);
    for (int k = 0; k < 6; k++) begin
      x[k]   = longint'($signed(vin[16*k +: 16]));
      res[k] = 0;
    end
    for (int k = 0; k < 3; k++)
      p[k] = longint'($signed(frame_reg[REG_TRANS][16*k +: 16]));
    if (op == OP_POINT) begin
      for (int i = 0; i < 3; i++)
        res[i] = clip16(row_dot(i, x[0], x[1], x[2]) + p[i], flag);
    end else if (op == OP_MOTION || op == OP_FORCE) begin
      // motion: angular half rotates alone; force: the force half does
      first  = (op == OP_MOTION) ? 3 : 0;
      second = 3 - first;
      for (int i = 0; i < 3; i++)
        res[first+i] = clip16(row_dot(i, x[first], x[first+1], x[first+2]), flag);
      // p cross the clipped rotated half
      c[0] = (p[1] * res[first+2] - p[2] * res[first+1] + half) >>> VEC_FB;
      c[1] = (p[2] * res[first]   - p[0] * res[first+2] + half) >>> VEC_FB;
      c[2] = (p[0] * res[first+1] - p[1] * res[first]   + half) >>> VEC_FB;
      for (int i = 0; i < 3; i++)
        res[second+i] = clip16(row_dot(i, x[second], x[second+1], x[second+2]) + c[i],
                               flag);
    end
    for (int k = 0; k < 6; k++) o.r[16*k +: 16] = res[k][15:0];
    o.sat = flag;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_item(logic [1:0] op, logic [15:0] a0, logic [15:0] a1,
                                     logic [15:0] a2, logic [15:0] a3, logic [15:0] a4,
                                     logic [15:0] a5);
    vec_item_t it;
    it.drain = 1'b0;
    it.op    = op;
    it.data  = {a5, a4, a3, a2, a1, a0};
    pending_items.push_back(it);
  endfunction

  // Component value weighted toward the extremes and small magnitudes
  function automatic logic [15:0] rand_comp();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 16'h7FFF;
    if (roll == 1) return 16'h8000;
    if (roll == 2) return 16'h0000;
    if (roll == 3) return 16'($urandom_range(0, 255));
    if (roll == 4) return -16'($urandom_range(0, 255));
    return 16'($urandom);
  endfunction

  function automatic logic [1:0] rand_op();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return OP_NONE;
    if (roll < 7) return OP_POINT;
    if (roll < 13) return OP_MOTION;
    return OP_FORCE;
  endfunction

  function automatic logic [47:0] rand_reg();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Three translation entries of moderate size, so that few results clip
  function automatic logic [47:0] mild_offset();
    logic [47:0] v;
    for (int k = 0; k < 3; k++) v[16*k +: 16] = 16'($signed($urandom_range(0, 4095)) - 2048);
    return v;
  endfunction

  // Write one frame register over the APB port, then read it back
  task automatic cfg_write(input reg_idx_e idx, input logic [47:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    frame_reg[idx] = val;
    // keep psel high and go straight into the read setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[47:0] !== val)
      note_failure($sformatf("register %0d read back %h, expected %h",
                             idx, prdata[47:0], val));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every item is sent and every result is in, then let the pipeline settle
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Load a frame while idle, then queue a stretch of random items
  task automatic run_phase(input logic [47:0] row0, input logic [47:0] row1,
                           input logic [47:0] row2, input logic [47:0] trans,
                           input int n_items, input bit calm);
    vec_item_t it;
    wait_drained();
    cfg_write(REG_ROT0, row0);
    cfg_write(REG_ROT1, row1);
    cfg_write(REG_ROT2, row2);
    cfg_write(REG_TRANS, trans);
    calm_phase = calm;
    for (int n = 0; n < n_items; n++) begin
      it.op   = rand_op();
      it.data = {rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                 rand_comp()};
      // halfway through, hold the sender until the pipeline is empty
      it.drain = (n == n_items / 2);
      pending_items.push_back(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: feed pending items onto the input channel, predict on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      // record the expectation for the item accepted at this edge
      if (s_tvalid && s_tready)
        expected_results.push_back(transform_item(s_tuser, s_tdata));
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          s_tvalid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain && expected_results.size() != 0)) begin
          next_item = pending_items.pop_front();
          s_tvalid  <= 1'b1;
          s_tdata   <= next_item.data;
          s_tuser   <= next_item.op;
          send_gap  <= (calm_phase || $urandom_range(0, 2) != 0) ? 0 : gap_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result item against the oldest expectation and
  // stall the output channel at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result item with none expected: data %h sat %b",
                                 m_tdata, m_tuser));
        end else begin
          want = expected_results.pop_front();
          bad  = 1'b0;
          for (int k = 0; k < 6; k++)
            if (m_tdata[16*k +: 16] !== want.r[16*k +: 16]) bad = 1'b1;
          if (m_tuser[0] !== want.sat) bad = 1'b1;
          if (bad)
            note_failure($sformatf("expected r5..r0 %h sat %b, got %h sat %b",
                                   want.r, want.sat, m_tdata, m_tuser[0]));
        end
      end
      // drop tready for a random stretch, or hold it high
      if (recv_stall > 0) begin
        m_tready   <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
        m_tready   <= 1'b0;
        recv_stall <= gap_len() - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed items, random phases over several frames
  // ---------------------------------------------------------------------------
  initial begin
    // reset frame: identity rotation, zero translation
    frame_reg[REG_ROT0]  = 48'h0000_0000_4000;
    frame_reg[REG_ROT1]  = 48'h0000_4000_0000;
    frame_reg[REG_ROT2]  = 48'h4000_0000_0000;
    frame_reg[REG_TRANS] = 48'h0000_0000_0000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset frame: extremes of every field and every operation;
    // for a point the upper half is ignored and must come out zero
    queue_item(OP_POINT,  16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h1234, 16'h8000, 16'h7FFF);
    queue_item(OP_POINT,  16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    queue_item(OP_POINT,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_item(OP_POINT,  16'hFFFF, 16'h0001, 16'h8001, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_item(OP_MOTION, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000);
    queue_item(OP_MOTION, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000);
    queue_item(OP_FORCE,  16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0001, 16'hFFFF);
    queue_item(OP_FORCE,  16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    // the unused operation code gives zeros and no flag
    queue_item(OP_NONE,   16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF);
    queue_item(OP_NONE,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_item(OP_MOTION, 16'h0100, 16'h0200, 16'h0300, 16'h0040, 16'hFFC0, 16'h0080);
    queue_item(OP_FORCE,  16'h0100, 16'h0200, 16'h0300, 16'h0040, 16'hFFC0, 16'h0080);

    // Directed, largest rotation entries and offset: clipping on every path,
    // including a clipped rotated half feeding the cross product
    run_phase(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
              48'h7FFF_7FFF_7FFF, 0, 1'b0);
    queue_item(OP_POINT,  16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
    queue_item(OP_POINT,  16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
    queue_item(OP_POINT,  16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_item(OP_MOTION, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_item(OP_MOTION, 16'h0010, 16'h0010, 16'h0010, 16'h0001, 16'h0002, 16'h0003);
    queue_item(OP_FORCE,  16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
    queue_item(OP_FORCE,  16'h0001, 16'h0002, 16'h0003, 16'h0010, 16'h0010, 16'h0010);
    queue_item(OP_NONE,   16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);

    // Random phases
    run_phase(rand_reg(), rand_reg(), rand_reg(), rand_reg(), 150, 1'b0);
    // quarter turn about z with a moderate offset, streamed with no idling
    run_phase(48'h0000_C000_0000, 48'h0000_0000_4000, 48'h4000_0000_0000,
              mild_offset(), 150, 1'b1);
    // most negative entries everywhere
    run_phase(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
              48'h8000_8000_8000, 100, 1'b0);
    // zero rotation: only the offset survives, and only in points
    run_phase(48'h0, 48'h0, 48'h0, rand_reg(), 80, 1'b0);
    run_phase(rand_reg(), rand_reg(), rand_reg(), rand_reg(), 200, 1'b0);
    run_phase(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
              mild_offset(), 120, 1'b0);

    wait_drained();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
